// ----- sv/fpsd_pkg.sv -----
// Shared types and constants of the fractional pixel span drawer.
package fpsd_pkg;

   localparam int DEFAULT_MAX_LEDS = 1024;

   localparam int NUM_LEDS_W = 11;
   localparam int FIX_W      = 19;
   localparam int COLOR_W    = 24;
   localparam int INDEX_W    = 10;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic [NUM_LEDS_W-1:0] NUM_LEDS_RESET = 11'd1024;

   // Register map: one register, selected by bit 2 of the byte address.
   localparam logic REG_NUM_LEDS = 1'b0;

   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NARROW    = 2'd1,
      ST_BEYOND    = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic                  req_type;
      logic [FIX_W-1:0]      position;
      logic [FIX_W-1:0]      span_width;
      logic [COLOR_W-1:0]    color_rgb;
      logic [INDEX_W-1:0]    pixel_index;
   } req_payload_type;

   typedef struct packed {
      status_type            status;
      logic [COLOR_W-1:0]    pixel_rgb;
   } rsp_payload_type;

endpackage

// ----- sv/fpsd_pixel_mem.sv -----
// Pixel store: one write port and one read port with registered read data.
module fpsd_pixel_mem #(
   parameter int DEPTH = fpsd_pkg::DEFAULT_MAX_LEDS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [fpsd_pkg::COLOR_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [fpsd_pkg::COLOR_W-1:0] rd_data
);
   import fpsd_pkg::*;

   logic [COLOR_W-1:0] pixel_store_ff [DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pixel_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/fpsd_span_seq.sv -----
// Request sequencer: clearing pass, checks, and one read-modify-write per covered pixel.
module fpsd_span_seq #(
   parameter int MAX_LEDS = fpsd_pkg::DEFAULT_MAX_LEDS,
   parameter int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fpsd_pkg::NUM_LEDS_W-1:0] num_leds,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fpsd_pkg::req_payload_type       req_payload,
   output logic                            result_valid,
   input  logic                            result_take,
   output fpsd_pkg::rsp_payload_type       result,
   output logic                            wr_en,
   output logic [AW-1:0]                   wr_addr,
   output logic [fpsd_pkg::COLOR_W-1:0]    wr_data,
   output logic                            rd_en,
   output logic [AW-1:0]                   rd_addr,
   input  logic [fpsd_pkg::COLOR_W-1:0]    rd_data
);
   import fpsd_pkg::*;

   localparam int CUR_W = NUM_LEDS_W + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_PIX,
      S_WRITE,
      S_RDATA,
      S_DONE
   } state_type;

   // Fraction q (0..256) in 1/256 units: fade = 255*(256-q)/256, ch = ch*(256-fade)/256.
   function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] color,
                                                      input logic [8:0] q);
      logic [16:0]        prod;
      logic [8:0]         mul;
      logic [16:0]        ch;
      logic [COLOR_W-1:0] r;
      prod = 17'(9'd256 - q) * 17'd255;
      mul  = 9'd256 - {1'b0, prod[15:8]};
      r    = '0;
      for (int i = 0; i < 3; i++) begin
         ch = 17'(color[8*i +: 8]) * 17'(mul);
         r[8*i +: 8] = ch[15:8];
      end
      return r;
   endfunction

   function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
      logic [8:0]         s;
      logic [COLOR_W-1:0] r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         s = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
         r[8*i +: 8] = s[8] ? 8'hFF : s[7:0];
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   req_payload_type      item_ff, item_in;
   logic [CUR_W-1:0]     cur_ff, cur_in;
   logic [FIX_W-1:0]     rem_ff, rem_in;
   logic                 head_ff, head_in;
   logic [COLOR_W-1:0]   add_color_ff, add_color_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   rsp_payload_type      result_ff, result_in;

   logic [NUM_LEDS_W-1:0] n;
   logic [FIX_W-1:0]      n256;
   logic [NUM_LEDS_W-1:0] ip;
   logic [7:0]            frac;
   logic [FIX_W:0]        diff;
   logic [FIX_W:0]        rem_clip;
   logic                  narrow, beyond, head_hit, idx_ok, cur_neg;
   logic [8:0]            q;
   logic [AW-1:0]         cur_addr;

   assign n        = (32'(num_leds) > MAX_LEDS) ? NUM_LEDS_W'(MAX_LEDS) : num_leds;
   assign n256     = {n, 8'd0};
   assign ip       = item_ff.position[FIX_W-1:8];
   assign frac     = item_ff.position[7:0];
   assign diff     = {1'b0, item_ff.position} - {1'b0, item_ff.span_width};
   assign rem_clip = {1'b0, item_ff.span_width} + {1'b0, n256} - {1'b0, item_ff.position};
   assign narrow   = (item_ff.span_width[FIX_W-1:8] == '0);
   assign beyond   = !diff[FIX_W] && (diff[FIX_W-1:0] > n256);
   assign head_hit = (ip < n);
   assign idx_ok   = ({1'b0, item_ff.pixel_index} < n);
   assign cur_neg  = cur_ff[CUR_W-1];
   assign cur_addr = AW'(cur_ff[CUR_W-2:0]);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      head_in      = head_ff;
      add_color_in = add_color_ff;
      wr_addr_in   = wr_addr_ff;
      result_in    = result_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_addr;
      wr_en        = 1'b0;
      wr_addr      = wr_addr_ff;
      wr_data      = sat_add(rd_data, add_color_ff);
      q            = 9'd256;

      case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            result_in.status    = ST_OK;
            result_in.pixel_rgb = '0;
            if (item_ff.req_type == REQ_READ) begin
               if (idx_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(item_ff.pixel_index);
                  state_in = S_RDATA;
               end else begin
                  result_in.status = ST_BAD_INDEX;
                  state_in         = S_DONE;
               end
            end else if (narrow) begin
               result_in.status = ST_NARROW;
               state_in         = S_DONE;
            end else if (beyond) begin
               result_in.status = ST_BEYOND;
               state_in         = S_DONE;
            end else begin
               head_in  = head_hit;
               if (head_hit) begin
                  cur_in = {1'b0, ip};
                  rem_in = item_ff.span_width - FIX_W'(frac);
               end else begin
                  // Edge lies past the strip: trim the overhang, start at the last pixel.
                  cur_in = {1'b0, n} - CUR_W'(1);
                  rem_in = rem_clip[FIX_W-1:0];
               end
               state_in = S_PIX;
            end
         end
         S_PIX: begin
            if (head_ff || (!cur_neg && rem_ff != '0)) begin
               if (head_ff) begin
                  q       = {1'b0, frac};
                  head_in = 1'b0;
               end else if (rem_ff[FIX_W-1:8] != '0) begin
                  q      = 9'd256;
                  rem_in = rem_ff - FIX_W'(256);
               end else begin
                  q      = rem_ff[8:0];
                  rem_in = '0;
               end
               rd_en        = 1'b1;
               rd_addr      = cur_addr;
               wr_addr_in   = cur_addr;
               add_color_in = scale_color(item_ff.color_rgb, q);
               cur_in       = cur_ff - CUR_W'(1);
               state_in     = S_WRITE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WRITE: begin
            wr_en    = 1'b1;
            state_in = S_PIX;
         end
         S_RDATA: begin
            result_in.pixel_rgb = rd_data;
            state_in            = S_DONE;
         end
         S_DONE: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         head_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         item_ff      <= item_in;
         cur_ff       <= cur_in;
         rem_ff       <= rem_in;
         head_ff      <= head_in;
         add_color_ff <= add_color_in;
         wr_addr_ff   <= wr_addr_in;
         result_ff    <= result_in;
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign result_valid = (state_ff == S_DONE);
   assign result       = result_ff;

   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> ($past(state_ff) == S_PIX && wr_addr == $past(rd_addr)))
      else $error("pixel write does not match the preceding read");

   a_pix_in_strip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PIX && rd_en) |-> (32'(rd_addr) < 32'(n)))
      else $error("span pixel outside the strip");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_CLEAR) |-> ($past(clr_addr_ff) == LAST_ADDR))
      else $error("clearing pass ended early");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !result_take) |=> (state_ff == S_DONE && $stable(result_ff)))
      else $error("result left before it was taken");

endmodule

// ----- sv/fractional_pixel_span_draw.sv -----
// Top level of the fractional pixel span drawer: register port, sequencer, store, output stage.
//
//   Channel  Ports                              Beat
//   req      req_valid / req_stall / req_payload  one draw or read request
//   rsp      rsp_valid / rsp_stall / rsp_payload  status and read-back pixel
//   csr      psel penable pwrite paddr pwdata ... num_leds at byte address 0
//
// After reset the block runs a clearing pass that writes black to every pixel; req_stall
// stays high for the whole pass, while register writes are taken as usual.
// A rejected request ends after its checks, a pixel read does one read of the pixel memory,
// and in a draw each covered pixel is one read and one write-back on the pixel memory.
// req_stall is high from acceptance until the result has moved to the output register.
// The output register holds one result, so a new request is taken while rsp is stalled.
module fractional_pixel_span_draw #(
   parameter int MAX_LEDS = fpsd_pkg::DEFAULT_MAX_LEDS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  fpsd_pkg::req_payload_type    req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output fpsd_pkg::rsp_payload_type    rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fpsd_pkg::PADDR_W-1:0] paddr,
   input  logic [fpsd_pkg::PDATA_W-1:0] pwdata,
   output logic [fpsd_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);
   import fpsd_pkg::*;

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   logic [NUM_LEDS_W-1:0] num_leds_ff, num_leds_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  result_valid, result_take;
   rsp_payload_type       result;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [COLOR_W-1:0]    wr_data, rd_data;

   // The register is selected by bit 2 of the byte address; everything above it reads zero.
   always_comb begin
      num_leds_in = num_leds_ff;
      if (psel && penable && pwrite && paddr[2] == REG_NUM_LEDS) begin
         num_leds_in = pwdata[NUM_LEDS_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_NUM_LEDS) ? PDATA_W'(num_leds_ff) : '0;

   // The output stage frees up in the same cycle its beat is taken.
   assign result_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (result_valid && result_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_leds_ff  <= NUM_LEDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_leds_ff    <= num_leds_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   fpsd_span_seq #(
      .MAX_LEDS (MAX_LEDS),
      .AW       (AW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .num_leds     (num_leds_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .result_valid (result_valid),
      .result_take  (result_take),
      .result       (result),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   fpsd_pixel_mem #(
      .DEPTH (MAX_LEDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
